// ----- design/sfd_pkg.sv -----
// Shared widths, register indexes and cell payload types for the spring force pipeline.
// No dependencies; used by every file of the block.
package sfd_pkg;

   localparam int PosW      = 32;
   localparam int DiffW     = 33;
   localparam int SqW       = 66;
   localparam int RadW      = 68;
   localparam int RootW     = 34;
   localparam int SRemW     = 36;
   localparam int LenW      = 34;
   localparam int DRemW     = 34;
   localparam int QuoW      = 31;
   localparam int ProdW     = 66;
   localparam int ChunkW    = 22;
   localparam int PartW     = 53;
   localparam int FullW     = 97;
   localparam int MagW      = 51;
   localparam int StiffW    = 32;
   localparam int RestW     = 31;
   localparam int SqrtSteps = 34;
   localparam int DivSteps  = 31;
   localparam int CsrIdxW   = 2;

   typedef logic [CsrIdxW-1:0] csr_index_type;
   localparam csr_index_type REG_STIFFNESS   = 2'd0;
   localparam csr_index_type REG_REST_LENGTH = 2'd1;

   localparam logic [StiffW-1:0] STIFFNESS_RESET = 32'h0001_0000;

   typedef struct packed {
      logic [RadW-1:0]             rad;
      logic [SRemW-1:0]            rem;
      logic [RootW-1:0]            root;
      logic [2:0][DiffW-1:0]       dm;
      logic [2:0]                  dneg;
   } sqrt_data_type;

   typedef struct packed {
      logic [2:0][DRemW-1:0]       rem;
      logic [2:0][QuoW-1:0]        quo;
      logic [2:0]                  nxt;
      logic [LenW-1:0]             len;
      logic [LenW-1:0]             fmag;
      logic                        fneg;
      logic [2:0]                  dneg;
      logic                        zero;
   } div_data_type;

endpackage

// ----- design/spring_force_3d.sv -----
// Hooke spring force between two bodies, Q16.16; chain of sqrt and divide cells.
// 74 register stages lie between the accepting edge and rsp_tvalid;
// one transaction per cycle while rsp_tready does not stall the chain.
// Throughput is set by the cell chain: every cell holds one item and hands it on each cycle,
// stalling only where the cell after it is full and stalled.
// Reset clears all valid bits; stiffness returns to 1.0 and rest length to 0.
// Depends on sfd_pkg, sfd_sqrt_cell, sfd_div_cell.
module spring_force_3d (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // parent_x, parent_y, parent_z, child_x, child_y, child_z
   input  logic [191:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // force_x, force_y, force_z
   output logic [95:0]  rsp_tdata,
   // saturated
   output logic [0:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  sfd_pkg::csr_index_type csr_index,
   input  logic [31:0]  csr_data
);

   localparam int PosW   = sfd_pkg::PosW;
   localparam int DiffW  = sfd_pkg::DiffW;
   localparam int SqW    = sfd_pkg::SqW;
   localparam int LenW   = sfd_pkg::LenW;
   localparam int QuoW   = sfd_pkg::QuoW;
   localparam int ProdW  = sfd_pkg::ProdW;
   localparam int ChunkW = sfd_pkg::ChunkW;
   localparam int PartW  = sfd_pkg::PartW;
   localparam int FullW  = sfd_pkg::FullW;
   localparam int MagW   = sfd_pkg::MagW;
   localparam int NSq    = sfd_pkg::SqrtSteps;
   localparam int NDiv   = sfd_pkg::DivSteps;

   // configuration
   logic [sfd_pkg::StiffW-1:0] stiffness_ff;
   logic [sfd_pkg::RestW-1:0]  rest_length_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stiffness_ff   <= sfd_pkg::STIFFNESS_RESET;
         rest_length_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            sfd_pkg::REG_STIFFNESS:   stiffness_ff   <= csr_data;
            sfd_pkg::REG_REST_LENGTH: rest_length_ff <= csr_data[sfd_pkg::RestW-1:0];
            default: ;
         endcase
      end
   end

   // stage enables, back to front
   logic en_a, en_b, en_c, en_d, en_e, en_g, en_h, en_j, en_k;
   logic a_v_ff, b_v_ff, c_v_ff, d_v_ff, e_v_ff, g_v_ff, h_v_ff, j_v_ff, k_v_ff;
   logic                   sq_v [NSq+1];
   logic                   sq_r [NSq+1];
   sfd_pkg::sqrt_data_type sq_d [NSq+1];
   logic                   dv_v [NDiv+1];
   logic                   dv_r [NDiv+1];
   sfd_pkg::div_data_type  dv_d [NDiv+1];

   assign en_k = !k_v_ff || rsp_tready;
   assign en_j = !j_v_ff || en_k;
   assign en_h = !h_v_ff || en_j;
   assign en_g = !g_v_ff || en_h;
   assign en_e = !e_v_ff || en_g;
   assign dv_r[NDiv] = en_e;
   assign en_d = !d_v_ff || dv_r[0];
   assign sq_r[NSq] = en_d;
   assign en_c = !c_v_ff || sq_r[0];
   assign en_b = !b_v_ff || en_c;
   assign en_a = !a_v_ff || en_b;
   assign req_tready = en_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0; b_v_ff <= 1'b0; c_v_ff <= 1'b0; d_v_ff <= 1'b0;
         e_v_ff <= 1'b0; g_v_ff <= 1'b0; h_v_ff <= 1'b0; j_v_ff <= 1'b0;
         k_v_ff <= 1'b0;
      end else begin
         if (en_a) a_v_ff <= req_tvalid;
         if (en_b) b_v_ff <= a_v_ff;
         if (en_c) c_v_ff <= b_v_ff;
         if (en_d) d_v_ff <= sq_v[NSq];
         if (en_e) e_v_ff <= dv_v[NDiv];
         if (en_g) g_v_ff <= e_v_ff;
         if (en_h) h_v_ff <= g_v_ff;
         if (en_j) j_v_ff <= h_v_ff;
         if (en_k) k_v_ff <= j_v_ff;
      end
   end

   // stage A: difference vector, split into magnitude and sign
   logic [DiffW-1:0] a_dm_ff [3], a_dm_in [3];
   logic [2:0]       a_dneg_ff, a_dneg_in;
   logic [DiffW-1:0] a_diff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_diff[i] = {req_tdata[PosW*(i+3)+PosW-1], req_tdata[PosW*(i+3) +: PosW]}
                   - {req_tdata[PosW*i+PosW-1], req_tdata[PosW*i +: PosW]};
         a_dneg_in[i] = a_diff[i][DiffW-1];
         a_dm_in[i]   = a_dneg_in[i] ? DiffW'(-a_diff[i]) : a_diff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_dm_ff   <= a_dm_in;
         a_dneg_ff <= a_dneg_in;
      end
   end

   // stage B: squares
   logic [SqW-1:0]   b_sq_ff [3];
   logic [DiffW-1:0] b_dm_ff [3];
   logic [2:0]       b_dneg_ff;

   always_ff @(posedge clock) begin
      if (en_b) begin
         for (int i = 0; i < 3; i++) begin
            b_sq_ff[i] <= SqW'(a_dm_ff[i]) * SqW'(a_dm_ff[i]);
         end
         b_dm_ff   <= a_dm_ff;
         b_dneg_ff <= a_dneg_ff;
      end
   end

   // stage C: squared length, seeds the root chain
   sfd_pkg::sqrt_data_type c_data_ff, c_data_in;

   always_comb begin
      c_data_in.rad  = {2'b00, SqW'(b_sq_ff[0] + b_sq_ff[1] + b_sq_ff[2])};
      c_data_in.rem  = '0;
      c_data_in.root = '0;
      for (int i = 0; i < 3; i++) begin
         c_data_in.dm[i] = b_dm_ff[i];
      end
      c_data_in.dneg = b_dneg_ff;
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         c_data_ff <= c_data_in;
      end
   end

   assign sq_v[0] = c_v_ff;
   assign sq_d[0] = c_data_ff;

   for (genvar k = 0; k < NSq; k++) begin : g_sqrt
      sfd_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_v[k]),
         .in_data   (sq_d[k]),
         .in_ready  (sq_r[k]),
         .out_valid (sq_v[k+1]),
         .out_ready (sq_r[k+1]),
         .out_data  (sq_d[k+1])
      );
   end

   // stage D: extension and divider seed
   sfd_pkg::div_data_type d_data_ff, d_data_in;
   logic [LenW:0]         d_f;

   always_comb begin
      d_f = {1'b0, sq_d[NSq].root} - (LenW+1)'(rest_length_ff);
      d_data_in.len  = sq_d[NSq].root;
      d_data_in.fneg = d_f[LenW];
      d_data_in.fmag = d_f[LenW] ? LenW'(-d_f) : d_f[LenW-1:0];
      d_data_in.zero = sq_d[NSq].root == '0;
      d_data_in.dneg = sq_d[NSq].dneg;
      for (int i = 0; i < 3; i++) begin
         d_data_in.rem[i] = sfd_pkg::DRemW'(sq_d[NSq].dm[i][DiffW-1:1]);
         d_data_in.nxt[i] = sq_d[NSq].dm[i][0];
         d_data_in.quo[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en_d) begin
         d_data_ff <= d_data_in;
      end
   end

   assign dv_v[0] = d_v_ff;
   assign dv_d[0] = d_data_ff;

   for (genvar k = 0; k < NDiv; k++) begin : g_div
      sfd_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_v[k]),
         .in_data   (dv_d[k]),
         .in_ready  (dv_r[k]),
         .out_valid (dv_v[k+1]),
         .out_ready (dv_r[k+1]),
         .out_data  (dv_d[k+1])
      );
   end

   // stage E: stiffness times extension, in two partial products
   logic [63:0]     e_plo_ff;
   logic [33:0]     e_phi_ff;
   logic [QuoW-1:0] e_quo_ff [3];
   logic [2:0]      e_neg_ff;
   logic            e_zero_ff;

   always_ff @(posedge clock) begin
      if (en_e) begin
         e_plo_ff  <= 64'(stiffness_ff) * 64'(dv_d[NDiv].fmag[31:0]);
         e_phi_ff  <= 34'(stiffness_ff) * 34'(dv_d[NDiv].fmag[LenW-1:32]);
         for (int i = 0; i < 3; i++) begin
            e_quo_ff[i] <= dv_d[NDiv].quo[i];
            e_neg_ff[i] <= dv_d[NDiv].fneg ^ dv_d[NDiv].dneg[i];
         end
         e_zero_ff <= dv_d[NDiv].zero;
      end
   end

   // stage G
   logic [ProdW-1:0] g_p_ff;
   logic [QuoW-1:0]  g_quo_ff [3];
   logic [2:0]       g_neg_ff;
   logic             g_zero_ff;

   always_ff @(posedge clock) begin
      if (en_g) begin
         g_p_ff    <= ProdW'(e_plo_ff) + {e_phi_ff, 32'b0};
         g_quo_ff  <= e_quo_ff;
         g_neg_ff  <= e_neg_ff;
         g_zero_ff <= e_zero_ff;
      end
   end

   // stage H: three 22-bit slices times the direction cosine, per lane
   logic [PartW-1:0] h_pp_ff [3][3];
   logic [2:0]       h_neg_ff;
   logic             h_zero_ff;

   always_ff @(posedge clock) begin
      if (en_h) begin
         for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) begin
               h_pp_ff[i][c] <= PartW'(g_p_ff[c*ChunkW +: ChunkW]) * PartW'(g_quo_ff[i]);
            end
         end
         h_neg_ff  <= g_neg_ff;
         h_zero_ff <= g_zero_ff;
      end
   end

   // stage J: recombine, drop 46 fraction bits
   logic [MagW-1:0] j_mag_ff [3];
   logic [2:0]      j_neg_ff;
   logic            j_zero_ff;
   logic [FullW-1:0] j_full [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         j_full[i] = FullW'(h_pp_ff[i][0]) + (FullW'(h_pp_ff[i][1]) << ChunkW)
                   + (FullW'(h_pp_ff[i][2]) << (2*ChunkW));
      end
   end

   always_ff @(posedge clock) begin
      if (en_j) begin
         for (int i = 0; i < 3; i++) begin
            j_mag_ff[i] <= j_full[i][FullW-1 -: MagW];
         end
         j_neg_ff  <= h_neg_ff;
         j_zero_ff <= h_zero_ff;
      end
   end

   // stage K: clamp, apply sign; coincident bodies give zero force
   logic [95:0]     k_data_ff, k_data_in;
   logic            k_sat_ff, k_sat_in;
   logic [MagW-1:0] k_limit [3];
   logic [2:0]      k_over;
   logic [PosW-1:0] k_m [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         k_limit[i] = j_neg_ff[i] ? MagW'(64'h8000_0000) : MagW'(64'h7FFF_FFFF);
         k_over[i]  = j_mag_ff[i] > k_limit[i];
         k_m[i]     = k_over[i] ? k_limit[i][PosW-1:0] : j_mag_ff[i][PosW-1:0];
         k_data_in[PosW*i +: PosW] = j_zero_ff ? '0 : (j_neg_ff[i] ? PosW'(-k_m[i]) : k_m[i]);
      end
      k_sat_in = !j_zero_ff && (|k_over);
   end

   always_ff @(posedge clock) begin
      if (en_k) begin
         k_data_ff <= k_data_in;
         k_sat_ff  <= k_sat_in;
      end
   end

   assign rsp_tvalid = k_v_ff;
   assign rsp_tdata  = k_data_ff;
   assign rsp_tuser  = k_sat_ff;

   // a direction cosine never exceeds one
   a_quo_range: assert property (@(posedge clock) disable iff (reset)
      dv_v[NDiv] && !dv_d[NDiv].zero |->
         dv_d[NDiv].quo[0] <= QuoW'(1 << 30) && dv_d[NDiv].quo[1] <= QuoW'(1 << 30)
         && dv_d[NDiv].quo[2] <= QuoW'(1 << 30))
      else $error("direction quotient above one");

   // root remainder stays within 2*root
   a_root_rem: assert property (@(posedge clock) disable iff (reset)
      sq_v[NSq] |-> sq_d[NSq].rem <= {1'b0, sq_d[NSq].root, 1'b0})
      else $error("square root remainder out of range");

   a_sat_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata != '0)
      else $error("saturated transaction with zero force");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

// ----- design/sfd_sqrt_cell.sv -----
// One restoring square-root step: two radicand bits in, one root bit out.
// Depends on sfd_pkg.
module sfd_sqrt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  sfd_pkg::sqrt_data_type in_data,
   output logic                   in_ready,
   output logic                   out_valid,
   input  logic                   out_ready,
   output sfd_pkg::sqrt_data_type out_data
);

   logic                   valid_ff;
   sfd_pkg::sqrt_data_type data_ff, data_in;
   logic                   en;
   logic [sfd_pkg::SRemW+1:0] shifted, trial;

   assign en = !valid_ff || out_ready;

   always_comb begin
      shifted = {in_data.rem, in_data.rad[sfd_pkg::RadW-1 -: 2]};
      trial   = {2'b00, in_data.root, 2'b01};
      data_in = in_data;
      data_in.rad = {in_data.rad[sfd_pkg::RadW-3:0], 2'b00};
      if (shifted >= trial) begin
         data_in.rem  = sfd_pkg::SRemW'(shifted - trial);
         data_in.root = {in_data.root[sfd_pkg::RootW-2:0], 1'b1};
      end else begin
         data_in.rem  = sfd_pkg::SRemW'(shifted);
         data_in.root = {in_data.root[sfd_pkg::RootW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign in_ready  = en;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- design/sfd_div_cell.sv -----
// One restoring division step for all three lanes: one quotient bit per lane.
// Depends on sfd_pkg.
module sfd_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  sfd_pkg::div_data_type in_data,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output sfd_pkg::div_data_type out_data
);

   logic                  valid_ff;
   sfd_pkg::div_data_type data_ff, data_in;
   logic                  en;
   logic [sfd_pkg::DRemW:0] shifted [3];
   logic [2:0]              ge;

   assign en = !valid_ff || out_ready;

   always_comb begin
      data_in = in_data;
      for (int i = 0; i < 3; i++) begin
         shifted[i] = {in_data.rem[i], in_data.nxt[i]};
         ge[i]      = shifted[i] >= {1'b0, in_data.len};
         data_in.rem[i] = ge[i] ? sfd_pkg::DRemW'(shifted[i] - {1'b0, in_data.len})
                                : sfd_pkg::DRemW'(shifted[i]);
         data_in.quo[i] = {in_data.quo[i][sfd_pkg::QuoW-2:0], ge[i]};
      end
      // dividend carries only one live bit below the initial remainder
      data_in.nxt = 3'b000;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign in_ready  = en;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for spring_force_3d: random and corner-case position pairs, Q16.16.
// Predicts each force vector in-bench and compares it with the response stream; uses sfd_pkg.
module tb_top;

   typedef struct packed {
      logic [31:0] cz, cy, cx, pz, py, px;
   } pair_type;

   typedef struct packed {
      logic        sat;
      logic [31:0] fz, fy, fx;
   } force_type;

   localparam int Latency  = 74;
   localparam int StallMax = 20000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   sfd_pkg::csr_index_type csr_index = sfd_pkg::REG_STIFFNESS;
   logic [31:0]  csr_data = '0;

   spring_force_3d i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow copy of the register file
   logic [31:0]  k_stiff = sfd_pkg::STIFFNESS_RESET;
   logic [30:0]  k_rest  = '0;

   pair_type     pair_q[$];
   force_type    force_q[$];
   int           send_idle = 12;
   int           recv_idle = 79;
   int           hold_cycles = 0;
   int           mismatches = 0;
   int           quiet = 0;

   function automatic force_type spring_force(pair_type p);
      logic signed [32:0] d[3];
      logic [32:0]        dm[3];
      logic [65:0]        sq;
      logic [67:0]        trial;
      logic [33:0]        len;
      logic signed [35:0] f;
      logic [34:0]        fm;
      logic [63:0]        u;
      logic [127:0]       prod;
      logic [127:0]       mag;
      logic [31:0]        lim;
      logic               neg;
      force_type          r;
      d[0] = $signed(p.cx) - $signed(p.px);
      d[1] = $signed(p.cy) - $signed(p.py);
      d[2] = $signed(p.cz) - $signed(p.pz);
      sq = '0;
      for (int i = 0; i < 3; i++) begin
         dm[i] = d[i][32] ? -d[i] : d[i];
         sq = sq + 66'(dm[i]) * 66'(dm[i]);
      end
      len = '0;
      for (int b = 33; b >= 0; b--) begin
         trial = 68'(len | (34'd1 << b));
         if (trial * trial <= 68'(sq)) len = len | (34'd1 << b);
      end
      r = '0;
      if (len == 0) return r;
      f = $signed({2'b0, len}) - $signed({5'b0, k_rest});
      fm = f[35] ? 35'(-f) : 35'(f);
      for (int i = 0; i < 3; i++) begin
         u = (64'(dm[i]) << 30) / 64'(len);
         prod = 128'(k_stiff) * 128'(fm) * 128'(u);
         mag = prod >> 46;
         neg = f[35] != d[i][32];
         lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         if (mag > 128'(lim)) begin
            mag = 128'(lim);
            r.sat = 1'b1;
         end
         case (i)
            0: r.fx = neg ? -mag[31:0] : mag[31:0];
            1: r.fy = neg ? -mag[31:0] : mag[31:0];
            default: r.fz = neg ? -mag[31:0] : mag[31:0];
         endcase
      end
      return r;
   endfunction

   // driver: keeps valid high across back-to-back transactions
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (pair_q.size() > 0 && $urandom_range(99) >= send_idle) begin
               req_tdata  <= pair_q[0];
               force_q.push_back(spring_force(pair_q.pop_front()));
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= !reset && ($urandom_range(99) >= recv_idle);
      end
   end

   // monitor
   always @(posedge clock) begin
      force_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata};
         if (force_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            want = force_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display(
                     "force mismatch: exp fx %h fy %h fz %h sat %b, got fx %h fy %h fz %h sat %b",
                     want.fx, want.fy, want.fz, want.sat,
                     got.fx, got.fy, got.fz, got.sat);
            end
         end
      end
   end

   // watchdog on cycles with no transaction anywhere
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet > StallMax) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic write_reg(sfd_pkg::csr_index_type idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == sfd_pkg::REG_STIFFNESS) k_stiff = val;
      else if (idx == sfd_pkg::REG_REST_LENGTH) k_rest = val[30:0];
   endtask

   task automatic drain();
      wait (pair_q.size() == 0 && !req_tvalid && force_q.size() == 0);
      repeat (Latency + 10) @(posedge clock);
   endtask

   function automatic logic [31:0] rnd_pos(int kind);
      case (kind)
         0: return $urandom;
         1: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
         2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         default: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(255)
                                           : 32'h8000_0000 + $urandom_range(255);
      endcase
   endfunction

   task automatic random_pairs(int n);
      pair_type p;
      int kind;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(9) < 6 ? 1 : $urandom_range(3);
         p = {rnd_pos(kind), rnd_pos(kind), rnd_pos(kind),
              rnd_pos(kind), rnd_pos(kind), rnd_pos(kind)};
         // sometimes the child sits on the parent
         if ($urandom_range(29) == 0) p.cx = p.px;
         if ($urandom_range(29) == 0) {p.cx, p.cy, p.cz} = {p.px, p.py, p.pz};
         pair_q.push_back(p);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directed: coincident, axis-aligned, extremes, compression
      pair_q.push_back('0);
      pair_q.push_back({96'h0, {3{32'h8000_0000}}});
      pair_q.push_back({{3{32'h1234_0000}}, {3{32'h1234_0000}}});
      pair_q.push_back({32'h0, 32'h0, 32'h0001_0000, 96'h0});
      pair_q.push_back({32'h0, 32'hFFFF_0000, 32'h0, 96'h0});
      pair_q.push_back({32'h0000_0001, 32'h0, 32'h0, 96'h0});
      pair_q.push_back({{3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}});
      pair_q.push_back({{3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}});
      pair_q.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
      pair_q.push_back({32'h0003_0000, 32'h0004_0000, 32'h0, 96'h0});
      drain();
      write_reg(sfd_pkg::REG_STIFFNESS, 32'hFFFF_FFFF);
      write_reg(sfd_pkg::REG_REST_LENGTH, 32'h0005_0000);
      pair_q.push_back({32'h0, 32'h0, 32'h0001_0000, 96'h0});
      pair_q.push_back({32'h0, 32'h0, 32'h0005_0000, 96'h0});
      pair_q.push_back({32'h0, 32'h0, 32'h0100_0000, 96'h0});
      pair_q.push_back({{3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}});
      pair_q.push_back('0);
      drain();
      write_reg(sfd_pkg::REG_STIFFNESS, 32'h0);
      write_reg(sfd_pkg::REG_REST_LENGTH, 32'h7FFF_FFFF);
      pair_q.push_back({32'h0, 32'h0, 32'h0100_0000, 96'h0});
      drain();
      write_reg(sfd_pkg::REG_STIFFNESS, 32'h0000_0001);
      write_reg(sfd_pkg::REG_REST_LENGTH, 32'hFFFF_FFFF);
      write_reg(sfd_pkg::csr_index_type'(2), 32'hDEAD_BEEF);
      write_reg(sfd_pkg::csr_index_type'(3), 32'h0);
      pair_q.push_back({32'h0, 32'h0, 32'h0100_0000, 96'h0});
      pair_q.push_back({{3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}});
      drain();

      // phase 1: sender idles lightly, receiver heavily
      write_reg(sfd_pkg::REG_STIFFNESS, sfd_pkg::STIFFNESS_RESET);
      write_reg(sfd_pkg::REG_REST_LENGTH, 32'h0);
      random_pairs(450);
      drain();
      // phase 2: the other way round, with a long receiver hold-off
      send_idle = 79;
      recv_idle = 12;
      write_reg(sfd_pkg::REG_STIFFNESS, $urandom);
      write_reg(sfd_pkg::REG_REST_LENGTH, $urandom_range(32'h0040_0000));
      send_idle = 0;
      random_pairs(150);
      hold_cycles = 400;
      wait (pair_q.size() == 0);
      send_idle = 79;
      random_pairs(350);
      drain();
      // phase 3: no idling, several settings
      send_idle = 0;
      recv_idle = 0;
      for (int s = 0; s < 4; s++) begin
         write_reg(sfd_pkg::REG_STIFFNESS, s == 0 ? 32'hFFFF_FFFF : $urandom);
         write_reg(sfd_pkg::REG_REST_LENGTH,
                   s == 1 ? 32'h7FFF_FFFF : $urandom_range(32'h0100_0000));
         random_pairs(190);
         drain();
      end

      if (mismatches == 0 && force_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
